[hdl/tcs_pkg.sv]
package tcs_pkg;

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_READ   = 10'b00_0000_0100,
        ST_PUT    = 10'b00_0000_1000,
        ST_PREP   = 10'b00_0001_0000,
        ST_CP_RD  = 10'b00_0010_0000,
        ST_CP_WR  = 10'b00_0100_0000,
        ST_FILL   = 10'b00_1000_0000,
        ST_FINISH = 10'b01_0000_0000,
        ST_SPARE  = 10'b10_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        PH_SAVE_TOP  = 3'd0,
        PH_SHIFT     = 3'd1,
        PH_RESTORE   = 3'd2,
        PH_SAVE_LIVE = 3'd3,
        PH_VIEW      = 3'd4
    } phase_t;

    localparam logic [1:0] ACT_PUT    = 2'd0;
    localparam logic [1:0] ACT_SCROLL = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [15:0] BLANK_CELL = 16'h0720;
    localparam logic [7:0]  DEF_ATTR   = 8'h07;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_BS      = 8'h08;
    localparam logic [7:0]  CH_NL      = 8'h0A;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_TAB     = 8'h09;
    localparam logic [2:0]  TAB_SPACES = 3'd5;

endpackage

[hdl/tcs_ram.sv]
module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/text_console_with_scrollback.sv]
// Text console with scrollback. Input words arrive on the s_ channel: a put
// writes a character at the cursor, a scroll moves the view into the saved
// rows, a read returns one displayed cell. Every input word gives exactly one
// result word on the m_ channel with the cursor, the cell (reads only) and
// the view and history depths.
// After reset the block blanks the screen memory, one cell a cycle, all
// COLUMNS * ROWS cells, with s_tready low; then it takes words.
// One word is handled at a time. A read passes ST_READ and a put that does
// not scroll ST_PUT before ST_FINISH; a scroll item that leaves the view
// unchanged goes straight to ST_FINISH. The copy engine moves a cell per
// read and write state between screen and ring: a put that scrolls saves
// the top row, shifts the screen up and blanks the last row; a put while
// scrolled back first restores the live screen; a view move from the live
// screen saves it before copying the view in; a tab is five puts.
// A new word is taken as soon as a result is in the output register;
// when the receiver stalls, the next result waits in the engine until the
// output register is free, and s_tready stays low until then.
module text_console_with_scrollback #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int SAVE_ROWS = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], char_word[17:2], scroll_delta[25:18], read_index[36:26]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cursor_pos[10:0], cell_data[26:11], backscroll_rows[33:27], history_rows[40:34]
    output logic [47:0] m_tdata
);

    import tcs_pkg::*;

    localparam int S    = COLUMNS * ROWS;
    localparam int RING = SAVE_ROWS * COLUMNS;
    localparam int MAXH = SAVE_ROWS - ROWS;
    localparam int AWS  = $clog2(S);
    localparam int AWR  = $clog2(RING);
    localparam int CW   = $clog2(S + 1);
    localparam int COLW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW   = $clog2(SAVE_ROWS);
    localparam int DW   = ((RW > 8) ? RW : 8) + 2;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [CW-1:0]     cursor_reg, cursor_next;
    logic [COLW-1:0]   col_reg, col_next;
    logic [RW-1:0]     start_reg, start_next;
    logic [RW-1:0]     used_reg, used_next;
    logic [RW-1:0]     back_reg, back_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [AWR-1:0]    src_reg, src_next;
    logic [AWR-1:0]    dst_reg, dst_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [2:0]        reps_reg, reps_next;
    logic [15:0]       word_reg, word_next;
    logic [15:0]       cell_reg, cell_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [47:0]       m_tdata_reg, m_tdata_next;

    logic              scr_we, ring_we;
    logic [AWS-1:0]    scr_waddr, scr_raddr;
    logic [AWR-1:0]    ring_waddr, ring_raddr;
    logic [15:0]       scr_wdata, ring_wdata, scr_rdata, ring_rdata;

    tcs_ram #(.WIDTH(16), .DEPTH(S)) u_screen (
        .aclk (aclk), .we (scr_we), .waddr (scr_waddr), .wdata (scr_wdata),
        .raddr (scr_raddr), .rdata (scr_rdata)
    );

    tcs_ram #(.WIDTH(16), .DEPTH(RING)) u_ring (
        .aclk (aclk), .we (ring_we), .waddr (ring_waddr), .wdata (ring_wdata),
        .raddr (ring_raddr), .rdata (ring_rdata)
    );

    logic [1:0]        in_action;
    logic [15:0]       in_word;
    logic signed [7:0] in_delta;
    logic [10:0]       in_index;

    assign in_action = s_tdata[1:0];
    assign in_word   = s_tdata[17:2];
    assign in_delta  = s_tdata[25:18];
    assign in_index  = s_tdata[36:26];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Ring row where the live screen is parked, and the first row shown.
    logic [RW:0]   live_sum, view_sum;
    logic [RW-1:0] live_row, view_row;
    assign live_sum = {1'b0, start_reg} + {1'b0, used_reg};
    assign live_row = (live_sum >= (RW+1)'(SAVE_ROWS)) ?
                      RW'(live_sum - (RW+1)'(SAVE_ROWS)) : live_sum[RW-1:0];
    assign view_sum = live_sum - {1'b0, back_reg};
    assign view_row = (view_sum >= (RW+1)'(SAVE_ROWS)) ?
                      RW'(view_sum - (RW+1)'(SAVE_ROWS)) : view_sum[RW-1:0];

    logic signed [DW-1:0] nb_s, used_s;
    logic [RW-1:0]        nb;
    assign nb_s   = DW'(back_reg) - DW'(in_delta);
    assign used_s = DW'(used_reg);
    always_comb begin
        if (nb_s > used_s) begin
            nb = used_reg;
        end else if (nb_s < 0) begin
            nb = '0;
        end else begin
            nb = nb_s[RW-1:0];
        end
    end

    logic src_ring, dst_ring;
    assign src_ring = (phase_reg == PH_RESTORE) || (phase_reg == PH_VIEW);
    assign dst_ring = (phase_reg == PH_SAVE_TOP) || (phase_reg == PH_SAVE_LIVE);

    logic [AWR-1:0] ring_base;
    assign ring_base = AWR'(row_reg * COLUMNS);

    logic [AWR-1:0] src_inc, dst_inc;
    assign src_inc = (src_ring && src_reg == AWR'(RING - 1)) ? '0 : src_reg + 1'b1;
    assign dst_inc = (dst_ring && dst_reg == AWR'(RING - 1)) ? '0 : dst_reg + 1'b1;

    // Plain put of the held word, and the history bookkeeping if it scrolls.
    logic [CW-1:0]   put_cursor;
    logic [COLW-1:0] put_col;
    logic [RW-1:0]   new_start, new_used, save_row;
    logic [RW:0]     save_sum;
    always_comb begin
        put_cursor = cursor_reg;
        put_col    = col_reg;
        case (word_reg[7:0])
            CH_BS: begin
                if (cursor_reg != '0) begin
                    put_cursor = cursor_reg - 1'b1;
                    put_col    = (col_reg == '0) ? COLW'(COLUMNS - 1) : col_reg - 1'b1;
                end
            end
            CH_NL: begin
                put_cursor = cursor_reg - CW'(col_reg) + CW'(COLUMNS);
                put_col    = '0;
            end
            CH_CR: begin
                put_cursor = cursor_reg - CW'(col_reg);
                put_col    = '0;
            end
            default: begin
                put_cursor = cursor_reg + 1'b1;
                put_col    = (col_reg == COLW'(COLUMNS - 1)) ? '0 : col_reg + 1'b1;
            end
        endcase
        if (used_reg >= RW'(MAXH)) begin
            new_start = (start_reg == RW'(SAVE_ROWS - 1)) ? '0 : start_reg + 1'b1;
            new_used  = used_reg;
        end else begin
            new_start = start_reg;
            new_used  = used_reg + 1'b1;
        end
        save_sum = {1'b0, new_start} + {1'b0, new_used} - 1'b1;
        save_row = (save_sum >= (RW+1)'(SAVE_ROWS)) ?
                   RW'(save_sum - (RW+1)'(SAVE_ROWS)) : save_sum[RW-1:0];
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cursor_next   = cursor_reg;
        col_next      = col_reg;
        start_next    = start_reg;
        used_next     = used_reg;
        back_next     = back_reg;
        row_next      = row_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        cnt_next      = cnt_reg;
        reps_next     = reps_reg;
        word_next     = word_reg;
        cell_next     = cell_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        scr_we        = 1'b0;
        scr_waddr     = dst_reg[AWS-1:0];
        scr_wdata     = BLANK_CELL;
        scr_raddr     = src_reg[AWS-1:0];
        ring_we       = 1'b0;
        ring_waddr    = dst_reg;
        ring_wdata    = scr_rdata;
        ring_raddr    = src_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                scr_we   = 1'b1;
                dst_next = dst_reg + 1'b1;
                if (dst_reg == AWR'(S - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                scr_raddr = in_index[AWS-1:0];
                if (s_tvalid) begin
                    cell_next = '0;
                    case (in_action)
                        ACT_PUT: begin
                            word_next = (in_word[15:8] == '0) ? {DEF_ATTR, in_word[7:0]}
                                                              : in_word;
                            if (in_word[7:0] == CH_TAB) begin
                                word_next = BLANK_CELL;
                                reps_next = TAB_SPACES;
                            end else begin
                                reps_next = 3'd1;
                            end
                            if (back_reg != '0) begin
                                row_next   = live_row;
                                phase_next = PH_RESTORE;
                                state_next = ST_PREP;
                            end else begin
                                state_next = ST_PUT;
                            end
                        end
                        ACT_SCROLL: begin
                            if (nb == back_reg) begin
                                state_next = ST_FINISH;
                            end else begin
                                back_next  = nb;
                                state_next = ST_PREP;
                                if (back_reg == '0) begin
                                    row_next   = live_row;
                                    phase_next = PH_SAVE_LIVE;
                                end else begin
                                    row_next   = RW'(live_sum - {1'b0, nb}
                                                 - (((live_sum - {1'b0, nb}) >=
                                                 (RW+1)'(SAVE_ROWS)) ?
                                                 (RW+1)'(SAVE_ROWS) : '0));
                                    phase_next = PH_VIEW;
                                end
                            end
                        end
                        ACT_READ: begin
                            state_next = (32'(in_index) < S) ? ST_READ : ST_FINISH;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_READ: begin
                cell_next  = scr_rdata;
                state_next = ST_FINISH;
            end
            ST_PUT: begin
                reps_next   = reps_reg - 1'b1;
                cursor_next = put_cursor;
                col_next    = put_col;
                if (word_reg[7:0] == CH_BS) begin
                    scr_we    = (cursor_reg != '0);
                    scr_waddr = put_cursor[AWS-1:0];
                    scr_wdata = {word_reg[15:8], CH_SPACE};
                end else if (word_reg[7:0] != CH_NL && word_reg[7:0] != CH_CR) begin
                    scr_we    = 1'b1;
                    scr_waddr = cursor_reg[AWS-1:0];
                    scr_wdata = word_reg;
                end
                if (32'(put_cursor) >= S) begin
                    start_next = new_start;
                    used_next  = new_used;
                    row_next   = save_row;
                    phase_next = PH_SAVE_TOP;
                    state_next = ST_PREP;
                end else if (reps_reg == 3'd1) begin
                    state_next = ST_FINISH;
                end
            end
            ST_PREP: begin
                state_next = ST_CP_RD;
                case (phase_reg)
                    PH_SAVE_TOP: begin
                        src_next = '0;
                        dst_next = ring_base;
                        cnt_next = CW'(COLUMNS);
                    end
                    PH_SHIFT: begin
                        src_next = AWR'(COLUMNS);
                        dst_next = '0;
                        cnt_next = CW'(S - COLUMNS);
                    end
                    PH_SAVE_LIVE: begin
                        src_next = '0;
                        dst_next = ring_base;
                        cnt_next = CW'(S);
                    end
                    default: begin
                        src_next = ring_base;
                        dst_next = '0;
                        cnt_next = CW'(S);
                    end
                endcase
            end
            ST_CP_RD: begin
                state_next = ST_CP_WR;
            end
            ST_CP_WR: begin
                if (dst_ring) begin
                    ring_we = 1'b1;
                end else begin
                    scr_we    = 1'b1;
                    scr_wdata = src_ring ? ring_rdata : scr_rdata;
                end
                src_next   = src_inc;
                dst_next   = dst_inc;
                cnt_next   = cnt_reg - 1'b1;
                state_next = ST_CP_RD;
                if (cnt_reg == CW'(1)) begin
                    case (phase_reg)
                        PH_SAVE_TOP: begin
                            if (ROWS > 1) begin
                                phase_next = PH_SHIFT;
                                state_next = ST_PREP;
                            end else begin
                                dst_next   = '0;
                                cnt_next   = CW'(COLUMNS);
                                state_next = ST_FILL;
                            end
                        end
                        PH_SHIFT: begin
                            dst_next   = AWR'(S - COLUMNS);
                            cnt_next   = CW'(COLUMNS);
                            state_next = ST_FILL;
                        end
                        PH_RESTORE: begin
                            back_next  = '0;
                            state_next = ST_PUT;
                        end
                        PH_SAVE_LIVE: begin
                            row_next   = view_row;
                            phase_next = PH_VIEW;
                            state_next = ST_PREP;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                scr_we   = 1'b1;
                dst_next = dst_reg + 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    cursor_next = cursor_reg - CW'(COLUMNS);
                    state_next  = (reps_reg != '0) ? ST_PUT : ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, 7'(used_reg), 7'(back_reg), cell_reg,
                                     11'(cursor_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            phase_reg    <= PH_SAVE_TOP;
            cursor_reg   <= '0;
            col_reg      <= '0;
            start_reg    <= '0;
            used_reg     <= '0;
            back_reg     <= '0;
            dst_reg      <= '0;
            cnt_reg      <= '0;
            reps_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cursor_reg   <= cursor_next;
            col_reg      <= col_next;
            start_reg    <= start_next;
            used_reg     <= used_next;
            back_reg     <= back_next;
            dst_reg      <= dst_next;
            cnt_reg      <= cnt_next;
            reps_reg     <= reps_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg     <= row_next;
        src_reg     <= src_next;
        word_reg    <= word_next;
        cell_reg    <= cell_next;
        m_tdata_reg <= m_tdata_next;
    end

    a_view_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        back_reg <= used_reg)
        else $error("view depth beyond history");

    a_history_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(used_reg) <= MAXH)
        else $error("history beyond capacity");

    a_cursor_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (32'(cursor_reg) < S))
        else $error("cursor off screen between words");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && state_next == ST_IDLE) |=> m_tvalid)
        else $error("finished word produced no result");

endmodule
